// ===== hdl/dvc_pkg.sv =====
// Package with shared constants and result kind codes for the duplicate value counter.
package dvc_pkg;

  localparam int unsigned MaxItemsDef   = 32;
  localparam int unsigned MinItemsReset = 5;
  localparam int unsigned ResultLimit   = 16;

  localparam int unsigned ValueW = 8;
  localparam int unsigned OccW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned KindW  = 2;

  localparam logic [OccW-1:0] OccMax = '1;

  localparam logic [KindW-1:0] KIND_DUP    = 2'd0;
  localparam logic [KindW-1:0] KIND_FEW    = 2'd1;
  localparam logic [KindW-1:0] KIND_NO_DUP = 2'd2;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [OccW-1:0]   occ;
  } entry_t;

endpackage

// ===== hdl/dvc_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module dvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/duplicate_value_counter.sv =====
// Duplicate value counter: stores a set of values and reports repeating ones when it closes.
//
//   channel   direction  beat contents
//   s_axis    in         tdata = value, tlast = final value of the set
//   m_axis    out        tuser = kind, tdata = dup_value, occurrences, overflow;
//                        tlast = final result of the set
//   cfg       in         cfg_data_i = min_items
//
// Loading a value scans the stored entries through the single read port of the entry RAM;
// the scan stops at the first earlier appearance. Closing a set scans the stored entries
// once more, one per cycle, pausing while each result beat waits for tready.
// Reset clears the fill count and the overflow flag; the RAM contents are not cleared.
// One set is worked on at a time; s_axis_tready is low while a value is being stored or
// while results are being produced.
module duplicate_value_counter
  import dvc_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MaxItemsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] value
  input  logic            s_axis_tlast,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata,   // [7:0] dup_value, [13:8] occurrences,
                                          // [14] overflow, [15] zero
  output logic [KindW-1:0] m_axis_tuser,  // [1:0] kind
  output logic            m_axis_tlast,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [MinW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CmpW = (CntW > MinW) ? CntW : MinW;
  localparam int unsigned NfW  = $clog2(ResultLimit + 1);
  localparam int unsigned EntW = ValueW + OccW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_WRHIT  = 3'd2;
  localparam logic [2:0] S_WRNEW  = 3'd3;
  localparam logic [2:0] S_RSTART = 3'd4;
  localparam logic [2:0] S_RSCAN  = 3'd5;
  localparam logic [2:0] S_RFLUSH = 3'd6;
  localparam logic [2:0] S_OUTW   = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [2:0]        ret_q, ret_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [MinW-1:0]   min_q;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [ValueW-1:0] val_q, val_d;
  logic              last_in_q, last_in_d;
  logic              new_one_q, new_one_d;
  logic [OccW-1:0]   hit_occ_q, hit_occ_d;
  logic [NfW-1:0]    nfound_q, nfound_d;
  logic              pend_q, pend_d;
  logic [ValueW-1:0] pend_val_q, pend_val_d;
  logic [OccW-1:0]   pend_occ_q, pend_occ_d;
  logic              ovalid_q, ovalid_d;
  logic [KindW-1:0]  okind_q, okind_d;
  logic [ValueW-1:0] oval_q, oval_d;
  logic [OccW-1:0]   oocc_q, oocc_d;
  logic              olast_q, olast_d;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  entry_t            ram_wdata;
  logic [IdxW-1:0]   ram_raddr;
  logic [EntW-1:0]   ram_rdata;
  entry_t            rd;
  logic              in_beat;
  logic              out_beat;
  logic              at_end;
  logic              match;
  logic              is_dup;

  dvc_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd        = entry_t'(ram_rdata);
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_beat  = m_axis_tvalid && m_axis_tready;
  assign at_end    = ((CntW'(idx_q) + CntW'(1)) == count_q);
  assign match     = (rd.value == val_q) && (rd.occ != '0);
  assign is_dup    = (rd.occ > OccW'(1));

  // The scans and the result wait read the entry after the current one; elsewhere entry 0 is read.
  assign ram_raddr = (state_q == S_SCAN || state_q == S_RSCAN || state_q == S_OUTW) ?
                     idx_q + IdxW'(1) : '0;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[IdxW-1:0];
    ram_wdata.value = val_q;
    ram_wdata.occ   = new_one_q ? OccW'(1) : '0;
    if (state_q == S_WRHIT) begin
      ram_we    = 1'b1;
      ram_waddr = idx_q;
      ram_wdata.occ = (hit_occ_q == OccMax) ? OccMax : hit_occ_q + OccW'(1);
    end else if (state_q == S_WRNEW) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    idx_d      = idx_q;
    val_d      = val_q;
    last_in_d  = last_in_q;
    new_one_d  = new_one_q;
    hit_occ_d  = hit_occ_q;
    nfound_d   = nfound_q;
    pend_d     = pend_q;
    pend_val_d = pend_val_q;
    pend_occ_d = pend_occ_q;
    ovalid_d   = ovalid_q;
    okind_d    = okind_q;
    oval_d     = oval_q;
    oocc_d     = oocc_q;
    olast_d    = olast_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          val_d     = s_axis_tdata;
          last_in_d = s_axis_tlast;
          idx_d     = '0;
          if (count_q == CntW'(MAX_ITEMS)) begin
            ovf_d = 1'b1;
            if (s_axis_tlast) begin
              state_d = S_RSTART;
            end
          end else if (count_q == '0) begin
            new_one_d = 1'b1;
            state_d   = S_WRNEW;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_occ_d = rd.occ;
          new_one_d = 1'b0;
          state_d   = S_WRHIT;
        end else if (at_end) begin
          new_one_d = 1'b1;
          state_d   = S_WRNEW;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_WRHIT: begin
        state_d = S_WRNEW;
      end
      S_WRNEW: begin
        count_d = count_q + CntW'(1);
        state_d = last_in_q ? S_RSTART : S_IDLE;
      end
      S_RSTART: begin
        idx_d    = '0;
        nfound_d = '0;
        pend_d   = 1'b0;
        if (CmpW'(count_q) < CmpW'(min_q)) begin
          ovalid_d = 1'b1;
          okind_d  = KIND_FEW;
          oval_d   = '0;
          oocc_d   = '0;
          olast_d  = 1'b1;
          ret_d    = S_IDLE;
          state_d  = S_OUTW;
        end else if (count_q == '0) begin
          state_d = S_RFLUSH;
        end else begin
          state_d = S_RSCAN;
        end
      end
      S_RSCAN: begin
        if (is_dup) begin
          nfound_d   = nfound_q + NfW'(1);
          pend_d     = 1'b1;
          pend_val_d = rd.value;
          pend_occ_d = rd.occ;
          // A held report goes out once the next one is known, so tlast lands correctly.
          if (pend_q) begin
            ovalid_d = 1'b1;
            okind_d  = KIND_DUP;
            oval_d   = pend_val_q;
            oocc_d   = pend_occ_q;
            olast_d  = 1'b0;
            ret_d    = (at_end || nfound_q == NfW'(ResultLimit - 1)) ? S_RFLUSH : S_RSCAN;
            state_d  = S_OUTW;
          end else if (at_end || nfound_q == NfW'(ResultLimit - 1)) begin
            state_d = S_RFLUSH;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end else if (at_end) begin
          state_d = S_RFLUSH;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_RFLUSH: begin
        ovalid_d = 1'b1;
        okind_d  = pend_q ? KIND_DUP : KIND_NO_DUP;
        oval_d   = pend_q ? pend_val_q : '0;
        oocc_d   = pend_q ? pend_occ_q : '0;
        olast_d  = 1'b1;
        ret_d    = S_IDLE;
        state_d  = S_OUTW;
      end
      S_OUTW: begin
        if (out_beat) begin
          ovalid_d = 1'b0;
          state_d  = ret_q;
          if (ret_q == S_RSCAN) begin
            idx_d = idx_q + IdxW'(1);
          end else if (ret_q == S_IDLE) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      min_q    <= MinW'(MinItemsReset);
      ovalid_q <= 1'b0;
      pend_q   <= 1'b0;
      nfound_q <= '0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
      pend_q   <= pend_d;
      nfound_q <= nfound_d;
      if (cfg_valid_i) begin
        min_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    val_q      <= val_d;
    last_in_q  <= last_in_d;
    new_one_q  <= new_one_d;
    hit_occ_q  <= hit_occ_d;
    pend_val_q <= pend_val_d;
    pend_occ_q <= pend_occ_d;
    okind_q    <= okind_d;
    oval_q     <= oval_d;
    oocc_q     <= oocc_d;
    olast_q    <= olast_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tdata  = {1'b0, ovf_q, oocc_q, oval_q};
  assign m_axis_tlast  = olast_q;

endmodule

// ===== verif/dvc_report_board.sv =====
// Expected-result predictor and result checker for the duplicate value counter testbench.
package dvc_report_board_pkg;
  import dvc_pkg::*;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] dup_value;
    logic [OccW-1:0]   occurrences;
    logic              overflow;
    logic              set_end;
  } dup_report_t;

  class dup_report_board;
    logic [ValueW-1:0] stored_value [MaxItemsDef];
    logic [OccW-1:0]   first_count  [MaxItemsDef];
    int unsigned       fill;
    bit                dropped;
    int unsigned       min_items;
    dup_report_t       expected_reports [$];

    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned sets_closed;
    int unsigned sets_dropped;
    int unsigned sets_few;
    int unsigned sets_clean;
    int unsigned sets_full;
    int unsigned settings_used;

    function new();
      fill      = 0;
      dropped   = 1'b0;
      min_items = MinItemsReset;
    endfunction

    function void set_min_items(logic [MinW-1:0] v);
      min_items = 32'(v);
      settings_used++;
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    // Stores a value or notes a drop if full; a closing value queues the set's reports.
    function void note_value(logic [ValueW-1:0] v, logic closes);
      dup_report_t set_reports [$];
      dup_report_t r;
      if (fill >= MaxItemsDef) begin
        dropped = 1'b1;
      end else begin
        first_count[fill] = OccW'(1);
        // Only the first appearance of a value keeps a nonzero count.
        for (int j = 0; j < fill; j++) begin
          if (stored_value[j] == v && first_count[j] != 0) begin
            if (first_count[j] != OccMax) first_count[j] = first_count[j] + 1'b1;
            first_count[fill] = '0;
            break;
          end
        end
        stored_value[fill] = v;
        fill++;
      end
      if (!closes) return;

      sets_closed++;
      if (dropped) sets_dropped++;
      r = '0;
      r.overflow = dropped;
      if (fill < min_items) begin
        r.kind = KIND_FEW;
        set_reports.push_back(r);
        sets_few++;
      end else begin
        for (int i = 0; i < fill && set_reports.size() < ResultLimit; i++) begin
          if (first_count[i] > 1) begin
            r.kind        = KIND_DUP;
            r.dup_value   = stored_value[i];
            r.occurrences = first_count[i];
            set_reports.push_back(r);
          end
        end
        if (set_reports.size() == 0) begin
          r.kind = KIND_NO_DUP;
          set_reports.push_back(r);
          sets_clean++;
        end else if (set_reports.size() == ResultLimit) begin
          sets_full++;
        end
      end
      r = set_reports.pop_back();
      r.set_end = 1'b1;
      set_reports.push_back(r);
      foreach (set_reports[i]) expected_reports.push_back(set_reports[i]);
      fill    = 0;
      dropped = 1'b0;
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      $display("MISMATCH at result %0d: %0s got %0d, expected %0d",
               results_checked, what, got, want);
    endtask

    task check_report(dup_report_t got);
      dup_report_t want;
      results_checked++;
      if (expected_reports.size() == 0) begin
        report_mismatch("result beat with nothing expected, kind", int'(got.kind), -1);
        return;
      end
      want = expected_reports.pop_front();
      if (got.kind != want.kind) report_mismatch("kind", int'(got.kind), int'(want.kind));
      if (got.dup_value != want.dup_value)
        report_mismatch("dup_value", int'(got.dup_value), int'(want.dup_value));
      if (got.occurrences != want.occurrences)
        report_mismatch("occurrences", int'(got.occurrences), int'(want.occurrences));
      if (got.overflow != want.overflow)
        report_mismatch("overflow", int'(got.overflow), int'(want.overflow));
      if (got.set_end != want.set_end)
        report_mismatch("tlast", int'(got.set_end), int'(want.set_end));
    endtask
  endclass

endpackage

// ===== verif/testbench.sv =====
// Top-level testbench: drives value sets and min_items writes, checks every result beat.
module testbench;
  import dvc_pkg::*;
  import dvc_report_board_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned NumPhases     = 6;

  typedef enum int {STYLE_POOL, STYLE_WIDE, STYLE_PAIRS} set_style_e;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata  = '0;   // [7:0] value
  logic            s_axis_tlast  = 1'b0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [15:0]     m_axis_tdata;         // [7:0] dup_value, [13:8] occurrences, [14] overflow
  logic [KindW-1:0] m_axis_tuser;        // [1:0] kind
  logic            m_axis_tlast;
  logic            cfg_valid_i   = 1'b0;
  logic            cfg_ready_o;
  logic [MinW-1:0] cfg_data_i    = '0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  dup_report_board sb = new();

  duplicate_value_counter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    dup_report_t got;
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_value(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind        = m_axis_tuser;
      got.dup_value   = m_axis_tdata[7:0];
      got.occurrences = m_axis_tdata[13:8];
      got.overflow    = m_axis_tdata[14];
      got.set_end     = m_axis_tlast;
      sb.check_report(got);
    end
  end

  // Ends the run when no beat moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no beat for %0d cycles, %0d results still expected",
             WatchdogLimit, sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_beat(logic [7:0] v, logic closes);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= closes;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_values(logic [7:0] vals [$]);
    foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
  endtask

  // The task waits for a clock edge before it polls, so that a beat accepted at the last edge is already noted.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_min_items(logic [MinW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_min_items(v);
  endtask

  // Builds one set of the given size and style and sends it, closing it on the last beat.
  task automatic send_set(int size, set_style_e style);
    logic [7:0] vals [$];
    logic [7:0] base;
    logic [7:0] tmp;
    int         pool;
    int         k;
    base = 8'($urandom_range(255));
    pool = $urandom_range(1, 6);
    for (int i = 0; i < size; i++) begin
      case (style)
        STYLE_POOL:  vals.push_back(8'(base + $urandom_range(pool - 1)));
        STYLE_WIDE:  vals.push_back(8'($urandom_range(255)));
        default:     vals.push_back(8'(base + i / 2));
      endcase
    end
    if (style == STYLE_PAIRS) begin
      for (int i = size - 1; i > 0; i--) begin
        k       = $urandom_range(i);
        tmp     = vals[i];
        vals[i] = vals[k];
        vals[k] = tmp;
      end
    end
    send_values(vals);
  endtask

  // Random sets: the first one holds 30 to 36 values, around the store depth, later ones are mostly short.
  task automatic run_random_sets(int budget);
    int sent;
    int size;
    int pick;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (sent == 0) size = $urandom_range(30, 36);
      else if (pick < 65) size = $urandom_range(1, 8);
      else if (pick < 90) size = $urandom_range(9, 20);
      else size = $urandom_range(21, 36);
      if (sent == 0) send_set(size, STYLE_PAIRS);
      else send_set(size, set_style_e'($urandom_range(2)));
      sent += size;
      if (!paused && sent >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    logic [MinW-1:0] min_plan  [NumPhases];
    int              item_plan [NumPhases];
    min_plan  = '{6'd0, 6'd63, 6'd32, 6'd33, 6'd1, 6'd5};
    item_plan = '{35, 30, 35, 30, 35, 35};
    min_plan[5] = MinW'($urandom_range(2, 31));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets at the reset value of min_items.
    send_values('{8'h00});
    send_values('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
    send_values('{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80});
    send_values('{8'h5A, 8'h5A, 8'h5A, 8'h5A});
    send_values('{8'hA5, 8'h3C, 8'hA5, 8'hC3, 8'h3C, 8'h3C});

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      repeat (SettleCycles) @(posedge clk_i);
      write_min_items(min_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      run_random_sets(item_plan[p]);
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Checked %0d result beats from %0d sets under %0d min_items settings.",
             sb.results_checked, sb.sets_closed, sb.settings_used);
    $display("Sets with dropped values %0d, too few %0d, no repeats %0d, full report %0d.",
             sb.sets_dropped, sb.sets_few, sb.sets_clean, sb.sets_full);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
